@@ rtl/core/apps_pkg.sv @@
// Shared types, constants and helpers of the platform physics step block.
package apps_pkg;

  localparam int NUM_PLATFORMS = 16;
  localparam int IDX_W = (NUM_PLATFORMS > 1) ? $clog2(NUM_PLATFORMS) : 1;
  localparam int CNT_W = IDX_W + 1;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TICK = 2'd1;
  localparam logic [1:0] FUNC_SETPOS = 2'd2;

  localparam logic [2:0] REG_MOVE_SPEED = 3'd0;
  localparam logic [2:0] REG_JUMP_POWER = 3'd1;
  localparam logic [2:0] REG_ACCEL_X = 3'd2;
  localparam logic [2:0] REG_ACCEL_Y = 3'd3;
  localparam logic [2:0] REG_ENT_WIDTH = 3'd4;
  localparam logic [2:0] REG_ENT_HEIGHT = 3'd5;
  localparam logic [2:0] REG_ANIM_FRAMES = 3'd6;
  localparam logic [2:0] REG_ENT_ACTIVE = 3'd7;

  localparam logic [16:0] ANIM_STEP = 17'd16384;

  typedef struct packed {
    logic [1:0] func;
    logic [3:0] slot;
    logic signed [15:0] item_x;
    logic signed [15:0] item_y;
    logic [14:0] item_w;
    logic [14:0] item_h;
    logic item_active;
    logic [15:0] delta_time;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic jump;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic hit_top;
    logic hit_bottom;
    logic hit_left;
    logic hit_right;
    logic [5:0] anim_frame;
  } out_t;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [14:0] pw;
    logic [14:0] ph;
  } plat_t;

  localparam int PLAT_W = $bits(plat_t);

  // Clamp a widened Q8.8 value back into 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/apps_ram.sv @@
// Generic single write port RAM with a registered read port.
module apps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic clk_i,
  input  logic we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/aabb_platform_physics_step.sv @@
// Top level of the platform physics step block: sequencer, shared multiplier and resolver.
// A load or set-position transaction does not stall the input. A tick with the entity active keeps
// the input stalled from its acceptance through the integration states S_M0 to S_M7, which use
// one shared 17 x 17 multiplier, a pass over the platform RAM after the Y update and another
// after the X update, one entry per cycle through its single read port, and the load of the
// output register, which waits while a previous result is still stalled there. The platform
// store is ready straight after reset; slot valid bits live in flip-flops. Inputs are taken
// only in the idle state, also while an earlier result still waits on the output register.
module aabb_platform_physics_step (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  apps_pkg::in_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output apps_pkg::out_t out_data_o,
  input  logic cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import apps_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_M0 = 4'd1;
  localparam logic [3:0] S_M1 = 4'd2;
  localparam logic [3:0] S_M2 = 4'd3;
  localparam logic [3:0] S_M3 = 4'd4;
  localparam logic [3:0] S_M4 = 4'd5;
  localparam logic [3:0] S_M5 = 4'd6;
  localparam logic [3:0] S_RY = 4'd7;
  localparam logic [3:0] S_M6 = 4'd8;
  localparam logic [3:0] S_M7 = 4'd9;
  localparam logic [3:0] S_RX = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;

  logic [3:0] state_q, state_d;

  logic [14:0] move_speed_q;
  logic signed [15:0] jump_power_q, accel_x_q, accel_y_q;
  logic [14:0] ent_w_q, ent_h_q;
  logic [6:0] anim_frames_q;
  logic ent_active_q;

  logic signed [15:0] x_q, x_d, y_q, y_d, vx_q, vx_d, vy_q, vy_d;
  logic [15:0] timer_q, timer_d;
  logic [5:0] aidx_q, aidx_d;
  logic [3:0] hits_q, hits_d;

  in_t tk_q;
  logic signed [33:0] prod_q, prod_d;
  logic signed [16:0] mul_a, mul_b;

  logic [NUM_PLATFORMS-1:0] pvalid_q;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic rd_vld_q;
  logic [IDX_W-1:0] rd_sel_q;

  logic ram_we, ram_re;
  plat_t ram_wdata, plat;
  logic [PLAT_W-1:0] ram_rdata;

  logic out_valid_q;
  out_t out_q;

  logic in_acc, load_ok;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign load_ok = (32'(in_data_i.slot) < NUM_PLATFORMS);
  assign ram_we = in_acc && (in_data_i.func == FUNC_LOAD) && load_ok;
  assign ram_wdata = '{px: in_data_i.item_x, py: in_data_i.item_y,
                       pw: in_data_i.item_w, ph: in_data_i.item_h};
  assign ram_re = ((state_q == S_RY) || (state_q == S_RX)) && (32'(idx_q) < NUM_PLATFORMS);

  apps_ram #(.WIDTH(PLAT_W), .DEPTH(NUM_PLATFORMS)) u_plat_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(IDX_W'(in_data_i.slot)),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(idx_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );
  assign plat = plat_t'(ram_rdata);

  // Overlap test and penetration against the entry read in the previous cycle.
  logic signed [17:0] ddx, ddy;
  logic [16:0] adx, ady;
  logic [15:0] sum_w, sum_h;
  logic overlap, is_y;
  logic [18:0] pen2;
  logic [17:0] pen;
  logic signed [15:0] pos_a, vel_a;
  logic signed [19:0] pos_res;

  always_comb begin
    ddx = 18'(x_q) - 18'(plat.px);
    ddy = 18'(y_q) - 18'(plat.py);
    adx = ddx[17] ? 17'(-ddx) : 17'(ddx);
    ady = ddy[17] ? 17'(-ddy) : 17'(ddy);
    sum_w = 16'(ent_w_q) + 16'(plat.pw);
    sum_h = 16'(ent_h_q) + 16'(plat.ph);
    overlap = rd_vld_q && pvalid_q[rd_sel_q] &&
              ({adx, 1'b0} < 18'(sum_w)) && ({ady, 1'b0} < 18'(sum_h));
    is_y = (state_q == S_RY);
    pos_a = is_y ? y_q : x_q;
    vel_a = is_y ? vy_q : vx_q;
    pen2 = is_y ? (19'(sum_h) - 19'({ady, 1'b0})) : (19'(sum_w) - 19'({adx, 1'b0}));
    pen = 18'((pen2 + 19'd1) >> 1);
    if (vel_a > 16'sd0) begin
      pos_res = 20'(pos_a) - $signed({2'b00, pen});
    end else begin
      pos_res = 20'(pos_a) + $signed({2'b00, pen});
    end
  end

  // Operand selection of the shared multiplier.
  always_comb begin
    unique case (state_q)
      S_M0: begin
        mul_a = 17'(tk_q.move_x);
        mul_b = $signed({2'b00, move_speed_q});
      end
      S_M1: begin
        mul_a = 17'(accel_x_q);
        mul_b = $signed({1'b0, tk_q.delta_time});
      end
      S_M2: begin
        mul_a = 17'(accel_y_q);
        mul_b = $signed({1'b0, tk_q.delta_time});
      end
      S_M4: begin
        mul_a = 17'(vy_q);
        mul_b = $signed({1'b0, tk_q.delta_time});
      end
      S_M6: begin
        mul_a = 17'(vx_q);
        mul_b = $signed({1'b0, tk_q.delta_time});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic [16:0] tsum;
  logic [6:0] nxt_idx;
  logic signed [25:0] spd_sh;

  always_comb begin
    state_d = state_q;
    x_d = x_q;
    y_d = y_q;
    vx_d = vx_q;
    vy_d = vy_q;
    timer_d = timer_q;
    aidx_d = aidx_q;
    hits_d = hits_q;
    idx_d = idx_q;
    prod_d = mul_a * mul_b;
    tsum = 17'(timer_q) + 17'(tk_q.delta_time);
    nxt_idx = 7'(aidx_q) + 7'd1;
    // The speed product reaches well beyond 20 bits, so it is clamped at full width.
    spd_sh = 26'(prod_q >>> 8);
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.func == FUNC_SETPOS) begin
            x_d = in_data_i.item_x;
            y_d = in_data_i.item_y;
            vx_d = '0;
            vy_d = '0;
          end else if ((in_data_i.func == FUNC_TICK) && ent_active_q) begin
            state_d = S_M0;
          end
        end
      end
      S_M0: begin
        hits_d = '0;
        if (anim_frames_q != 7'd0) begin
          if ((tk_q.move_x != 16'sd0) || (tk_q.move_y != 16'sd0)) begin
            timer_d = tsum[16] ? 16'hFFFF : tsum[15:0];
            if ((tsum[16] ? 17'h0FFFF : tsum) >= ANIM_STEP) begin
              timer_d = '0;
              aidx_d = ((nxt_idx >= anim_frames_q) || (nxt_idx >= 7'd64)) ? 6'd0
                       : nxt_idx[5:0];
            end
          end else begin
            aidx_d = '0;
          end
        end
        if (tk_q.jump) begin
          vy_d = sat16(20'(vy_q) + 20'(jump_power_q));
        end
        state_d = S_M1;
      end
      S_M1: begin
        if (spd_sh > 26'sd32767) begin
          vx_d = 16'sh7FFF;
        end else if (spd_sh < -26'sd32768) begin
          vx_d = 16'sh8000;
        end else begin
          vx_d = spd_sh[15:0];
        end
        state_d = S_M2;
      end
      S_M2: begin
        vx_d = sat16(20'(vx_q) + 20'(prod_q >>> 16));
        state_d = S_M3;
      end
      S_M3: begin
        vy_d = sat16(20'(vy_q) + 20'(prod_q >>> 16));
        state_d = S_M4;
      end
      S_M4: begin
        state_d = S_M5;
      end
      S_M5: begin
        y_d = sat16(20'(y_q) + 20'(prod_q >>> 16));
        idx_d = '0;
        state_d = S_RY;
      end
      S_RY, S_RX: begin
        if (overlap && (vel_a != 16'sd0)) begin
          if (is_y) begin
            y_d = sat16(pos_res);
            vy_d = '0;
            if (vel_a > 16'sd0) hits_d[3] = 1'b1;
            else hits_d[2] = 1'b1;
          end else begin
            x_d = sat16(pos_res);
            vx_d = '0;
            if (vel_a > 16'sd0) hits_d[0] = 1'b1;
            else hits_d[1] = 1'b1;
          end
        end
        if (32'(idx_q) < NUM_PLATFORMS) begin
          idx_d = idx_q + CNT_W'(1);
        end else begin
          state_d = is_y ? S_M6 : S_OUT;
        end
      end
      S_M6: begin
        state_d = S_M7;
      end
      S_M7: begin
        x_d = sat16(20'(x_q) + 20'(prod_q >>> 16));
        idx_d = '0;
        state_d = S_RX;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      move_speed_q <= 15'd256;
      jump_power_q <= '0;
      accel_x_q <= '0;
      accel_y_q <= '0;
      ent_w_q <= 15'd256;
      ent_h_q <= 15'd256;
      anim_frames_q <= '0;
      ent_active_q <= 1'b1;
      x_q <= '0;
      y_q <= '0;
      vx_q <= '0;
      vy_q <= '0;
      timer_q <= '0;
      aidx_q <= '0;
      hits_q <= '0;
      idx_q <= '0;
      rd_vld_q <= 1'b0;
      pvalid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      x_q <= x_d;
      y_q <= y_d;
      vx_q <= vx_d;
      vy_q <= vy_d;
      timer_q <= timer_d;
      aidx_q <= aidx_d;
      hits_q <= hits_d;
      idx_q <= idx_d;
      rd_vld_q <= ram_re;
      if (ram_we) begin
        pvalid_q[IDX_W'(in_data_i.slot)] <= in_data_i.item_active;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MOVE_SPEED: move_speed_q <= cfg_data_i[14:0];
          REG_JUMP_POWER: jump_power_q <= cfg_data_i;
          REG_ACCEL_X: accel_x_q <= cfg_data_i;
          REG_ACCEL_Y: accel_y_q <= cfg_data_i;
          REG_ENT_WIDTH: ent_w_q <= cfg_data_i[14:0];
          REG_ENT_HEIGHT: ent_h_q <= cfg_data_i[14:0];
          REG_ANIM_FRAMES: anim_frames_q <= cfg_data_i[6:0];
          REG_ENT_ACTIVE: ent_active_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if ((state_q == S_OUT) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rd_sel_q <= idx_q[IDX_W-1:0];
    if (in_acc) begin
      tk_q <= in_data_i;
    end
    if ((state_q == S_OUT) && (!out_valid_q || !out_stall_i)) begin
      out_q <= '{pos_x: x_q, pos_y: y_q, vel_x: vx_q, vel_y: vy_q,
                 hit_top: hits_q[3], hit_bottom: hits_q[2], hit_left: hits_q[1],
                 hit_right: hits_q[0], anim_frame: aidx_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && !(out_valid_q && out_stall_i) |=> out_valid_q && (state_q == S_IDLE))
    else $error("result transaction not loaded on leaving the output state");

  a_read_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> ((state_q == S_RY) || (state_q == S_RX)))
    else $error("platform read outside a resolution pass");

  a_hits_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_M0) |=> (hits_q == 4'b0000))
    else $error("hit flags not cleared at the start of a tick");

endmodule
